// File: sv/voxel_grid_ray_traversal_macros.svh
`ifndef VOXEL_GRID_RAY_TRAVERSAL_MACROS_SVH
`define VOXEL_GRID_RAY_TRAVERSAL_MACROS_SVH

// clocked check, muted while reset is high
`define VGRT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check, live through reset
`define VGRT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/vgrt_pkg.sv
package vgrt_pkg;

   localparam int GRID_SIDE_LOG2 = 4;
   localparam int FRACTION_BITS  = 12;
   localparam int GRID_SIDE      = 1 << GRID_SIDE_LOG2;
   localparam int ADDR_W         = 3 * GRID_SIDE_LOG2;
   localparam int CELL_COUNT     = 1 << ADDR_W;
   localparam int CELL_IN_W      = 4;
   localparam int ORG_W          = 16;
   localparam int DIR_W          = 16;
   localparam int DIST_W         = 20;
   localparam int NORM_W         = 2;
   localparam int DIR_FRAC       = 14;
   localparam int RECIP_BITS     = FRACTION_BITS + 21;
   localparam int QUO_W          = DIR_FRAC + FRACTION_BITS + 1;
   localparam int DEN_W          = DIR_W;
   localparam int REM_W          = DEN_W + 1;
   localparam int DCNT_W         = $clog2(QUO_W);
   localparam int SIDE_W         = RECIP_BITS + 3;
   localparam int F_W            = FRACTION_BITS + 1;
   localparam int PROD_W         = F_W + RECIP_BITS;
   localparam int CELL_W         = (23 - FRACTION_BITS > GRID_SIDE_LOG2 + 2) ?
                                   23 - FRACTION_BITS : GRID_SIDE_LOG2 + 2;

   localparam logic [RECIP_BITS-1:0] RECIP_MAX = '1;
   localparam logic [DIST_W-1:0]     DIST_MAX  = '1;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_RAY   = 1'b1;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [NORM_W-1:0] NORM_POS  = 2'sb01;
   localparam logic signed [NORM_W-1:0] NORM_NEG  = 2'sb11;
   localparam logic signed [NORM_W-1:0] NORM_NONE = 2'sb00;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL,
      ST_STEP,
      ST_TEST,
      ST_RESP
   } state_type;

endpackage

// File: sv/vgrt_ram.sv
module vgrt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/vgrt_div.sv
module vgrt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [vgrt_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic [vgrt_pkg::QUO_W-1:0] quotient
);
   import vgrt_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [REM_W-1:0]  shifted;
   logic              take;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      shifted = {rem_ff[REM_W-2:0], (cnt_ff == '0)};
      take    = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = take ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in = {quo_ff[QUO_W-2:0], take};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DCNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: sv/voxel_grid_ray_traversal.sv
// Ray caster over a 16x16x16 one-bit occupancy grid. A write word sets or clears one
// cell and answers with an all-zero result in the cycle after it is taken. A ray word
// runs a fixed-point 3D DDA: setup runs per axis through one shared divider
// (skipped for a zero direction component) and a multiply step, then each
// traversal step takes a step state and a test state because the occupancy RAM
// read is registered. The block takes one word at a time. After reset the grid
// RAM is swept to empty, one cell per cycle, so no word is taken until the sweep
// is done.
`include "voxel_grid_ray_traversal_macros.svh"

module voxel_grid_ray_traversal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [vgrt_pkg::CELL_IN_W-1:0]      req_cell_x,
   input  logic [vgrt_pkg::CELL_IN_W-1:0]      req_cell_y,
   input  logic [vgrt_pkg::CELL_IN_W-1:0]      req_cell_z,
   input  logic                                req_solid,
   input  logic [vgrt_pkg::ORG_W-1:0]          req_origin_x,
   input  logic [vgrt_pkg::ORG_W-1:0]          req_origin_y,
   input  logic [vgrt_pkg::ORG_W-1:0]          req_origin_z,
   input  logic signed [vgrt_pkg::DIR_W-1:0]   req_dir_x,
   input  logic signed [vgrt_pkg::DIR_W-1:0]   req_dir_y,
   input  logic signed [vgrt_pkg::DIR_W-1:0]   req_dir_z,
   input  logic [vgrt_pkg::DIST_W-1:0]         req_max_distance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [vgrt_pkg::CELL_IN_W-1:0]      rsp_hit_x,
   output logic [vgrt_pkg::CELL_IN_W-1:0]      rsp_hit_y,
   output logic [vgrt_pkg::CELL_IN_W-1:0]      rsp_hit_z,
   output logic signed [vgrt_pkg::NORM_W-1:0]  rsp_normal_x,
   output logic signed [vgrt_pkg::NORM_W-1:0]  rsp_normal_y,
   output logic signed [vgrt_pkg::NORM_W-1:0]  rsp_normal_z,
   output logic [vgrt_pkg::DIST_W-1:0]         rsp_hit_distance
);
   import vgrt_pkg::*;

   state_type state_ff, state_in;
   logic [1:0]         axis_ff, axis_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;

   logic [ORG_W-1:0]         org_ff [3];
   logic [ORG_W-1:0]         org_in [3];
   logic [DIR_W-1:0]         dir_ff [3];
   logic [DIR_W-1:0]         dir_in [3];
   logic [DIST_W-1:0]        limit_ff, limit_in;
   logic [RECIP_BITS-1:0]    recip_ff [3];
   logic [RECIP_BITS-1:0]    recip_in [3];
   logic [SIDE_W-1:0]        side_ff [3];
   logic [SIDE_W-1:0]        side_in [3];
   logic signed [CELL_W-1:0] cell_ff [3];
   logic signed [CELL_W-1:0] cell_in [3];
   logic                     stepneg_ff [3];
   logic                     stepneg_in [3];
   logic signed [NORM_W-1:0] normal_ff [3];
   logic signed [NORM_W-1:0] normal_in [3];
   logic [F_W-1:0]           f_ff, f_in;
   logic [SIDE_W-1:0]        trav_ff, trav_in;
   logic                     inside_ff, inside_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [CELL_IN_W-1:0]     rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic signed [NORM_W-1:0] rsp_n_ff [3];
   logic signed [NORM_W-1:0] rsp_n_in [3];
   logic [DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;

   logic [DIR_W-1:0]         d_sel;
   logic [ORG_W-1:0]         o_sel;
   logic                     d_neg;
   logic [DIR_W-1:0]         d_mag;
   logic [FRACTION_BITS-1:0] o_frac;
   logic [PROD_W-1:0]        prod;
   logic                     div_start, div_done;
   logic [QUO_W-1:0]         div_quo;
   logic                     lt01, lt02, lt12;
   logic [1:0]               pick;
   logic signed [CELL_W-1:0] ncell [3];

   logic              ram_we, ram_wd, ram_rd;
   logic [ADDR_W-1:0] ram_wa, ram_ra;

   vgrt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .den      (d_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   vgrt_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign d_sel  = dir_ff[axis_ff];
   assign o_sel  = org_ff[axis_ff];
   assign d_neg  = d_sel[DIR_W-1];
   assign d_mag  = d_neg ? (~d_sel + 1'b1) : d_sel;
   assign o_frac = o_sel[FRACTION_BITS-1:0];
   assign prod   = PROD_W'(f_ff) * PROD_W'(recip_ff[axis_ff]);

   assign lt01 = side_ff[0] < side_ff[1];
   assign lt02 = side_ff[0] < side_ff[2];
   assign lt12 = side_ff[1] < side_ff[2];
   assign pick = (lt01 && lt02) ? AXIS_X : (lt12 ? AXIS_Y : AXIS_Z);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ncell[i] = cell_ff[i];
         if (pick == 2'(i)) begin
            ncell[i] = cell_ff[i] + (stepneg_ff[i] ? {CELL_W{1'b1}} : CELL_W'(1));
         end
      end
   end

   assign ram_ra = {ncell[2][GRID_SIDE_LOG2-1:0], ncell[1][GRID_SIDE_LOG2-1:0],
                    ncell[0][GRID_SIDE_LOG2-1:0]};

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      clr_in       = clr_ff;
      org_in       = org_ff;
      dir_in       = dir_ff;
      limit_in     = limit_ff;
      recip_in     = recip_ff;
      side_in      = side_ff;
      cell_in      = cell_ff;
      stepneg_in   = stepneg_ff;
      normal_in    = normal_ff;
      f_in         = f_ff;
      trav_in      = trav_ff;
      inside_in    = inside_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_n_in     = rsp_n_ff;
      rsp_dist_in  = rsp_dist_ff;
      req_ready    = 1'b0;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      ram_wa       = clr_ff;
      ram_wd       = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_WRITE) begin
                  ram_we       = 1'b1;
                  ram_wa       = {GRID_SIDE_LOG2'(req_cell_z), GRID_SIDE_LOG2'(req_cell_y),
                                  GRID_SIDE_LOG2'(req_cell_x)};
                  ram_wd       = req_solid;
                  rsp_hit_in   = 1'b0;
                  rsp_x_in     = '0;
                  rsp_y_in     = '0;
                  rsp_z_in     = '0;
                  rsp_n_in     = '{NORM_NONE, NORM_NONE, NORM_NONE};
                  rsp_dist_in  = '0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  org_in    = '{req_origin_x, req_origin_y, req_origin_z};
                  dir_in    = '{req_dir_x, req_dir_y, req_dir_z};
                  limit_in  = req_max_distance;
                  normal_in = '{NORM_NONE, NORM_NONE, NORM_NONE};
                  trav_in   = '0;
                  axis_in   = AXIS_X;
                  state_in  = ST_DIV_START;
               end
            end
         end
         ST_DIV_START: begin
            stepneg_in[axis_ff] = d_neg || (d_sel == '0);
            cell_in[axis_ff]    = CELL_W'(o_sel >> FRACTION_BITS);
            f_in = d_neg ? F_W'(o_frac) : (F_W'(1 << FRACTION_BITS) - F_W'(o_frac));
            if (d_mag == '0) begin
               recip_in[axis_ff] = RECIP_MAX;
               state_in          = ST_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               recip_in[axis_ff] = RECIP_BITS'(div_quo);
               state_in          = ST_MUL;
            end
         end
         ST_MUL: begin
            side_in[axis_ff] = SIDE_W'(prod >> FRACTION_BITS);
            if (axis_ff == AXIS_Z) begin
               state_in = ST_STEP;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_DIV_START;
            end
         end
         ST_STEP: begin
            if (trav_ff >= SIDE_W'(limit_ff)) begin
               rsp_hit_in   = 1'b0;
               rsp_x_in     = '0;
               rsp_y_in     = '0;
               rsp_z_in     = '0;
               rsp_n_in     = normal_ff;
               rsp_dist_in  = '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               trav_in   = side_ff[pick];
               inside_in = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  normal_in[i] = NORM_NONE;
                  cell_in[i]   = ncell[i];
                  if (ncell[i][CELL_W-1:GRID_SIDE_LOG2] != '0) begin
                     inside_in = 1'b0;
                  end
                  if (pick == 2'(i)) begin
                     side_in[i]   = side_ff[i] + SIDE_W'(recip_ff[i]);
                     normal_in[i] = stepneg_ff[i] ? NORM_POS : NORM_NEG;
                  end
               end
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (inside_ff && ram_rd) begin
               rsp_hit_in   = 1'b1;
               rsp_x_in     = CELL_IN_W'(cell_ff[0][GRID_SIDE_LOG2-1:0]);
               rsp_y_in     = CELL_IN_W'(cell_ff[1][GRID_SIDE_LOG2-1:0]);
               rsp_z_in     = CELL_IN_W'(cell_ff[2][GRID_SIDE_LOG2-1:0]);
               rsp_n_in     = normal_ff;
               rsp_dist_in  = (trav_ff > SIDE_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(trav_ff);
               rsp_valid_in = 1'b1;
               state_in     = ST_RESP;
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_RESP: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      axis_ff     <= axis_in;
      org_ff      <= org_in;
      dir_ff      <= dir_in;
      limit_ff    <= limit_in;
      recip_ff    <= recip_in;
      side_ff     <= side_in;
      cell_ff     <= cell_in;
      stepneg_ff  <= stepneg_in;
      normal_ff   <= normal_in;
      f_ff        <= f_in;
      trav_ff     <= trav_in;
      inside_ff   <= inside_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
      rsp_n_ff    <= rsp_n_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_x        = rsp_x_ff;
   assign rsp_hit_y        = rsp_y_ff;
   assign rsp_hit_z        = rsp_z_ff;
   assign rsp_normal_x     = rsp_n_ff[0];
   assign rsp_normal_y     = rsp_n_ff[1];
   assign rsp_normal_z     = rsp_n_ff[2];
   assign rsp_hit_distance = rsp_dist_ff;

   `VGRT_ASSERT(a_rsp_in_resp, rsp_valid |-> state_ff == ST_RESP, "result word outside response state")
   `VGRT_ASSERT(a_miss_zero, rsp_valid && !rsp_hit |-> rsp_hit_distance == '0 && rsp_hit_x == '0, "miss carries hit data")
   `VGRT_ASSERT(a_div_wait, div_done |-> state_ff == ST_DIV_WAIT, "divider finished while not awaited")
   `VGRT_ASSERT(a_one_word, req_valid && req_ready |=> !req_ready, "second word taken while busy")

endmodule
